### rtl/playlist_track_selector_macros.svh
// ---------------------------------------------------------------------------
// Playlist track selector assertion macros
// Shared helpers for the concurrent checks of the selector.
// ---------------------------------------------------------------------------
`ifndef PLAYLIST_TRACK_SELECTOR_MACROS_SVH
`define PLAYLIST_TRACK_SELECTOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("playlist track selector check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("playlist track selector check failed");

`endif

### rtl/pts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playlist track selector package
// Word types, event codes, generator constants and controller states.
// ---------------------------------------------------------------------------
package pts_pkg;

   localparam int unsigned DEF_QUEUE_DEPTH = 256;

   localparam logic [31:0] LCG_MUL  = 32'd1103515245;
   localparam logic [31:0] LCG_ADD  = 32'd12345;
   localparam logic [31:0] LCG_SEED = 32'h2545F491;
   localparam logic [15:0] RESTART_SECONDS = 16'd3;
   // Bits of the generator state that feed the random pick.
   localparam int unsigned RND_BITS = 24;

   localparam logic [2:0] KIND_CLEAR       = 3'd0;
   localparam logic [2:0] KIND_ADD         = 3'd1;
   localparam logic [2:0] KIND_START       = 3'd2;
   localparam logic [2:0] KIND_END         = 3'd3;
   localparam logic [2:0] KIND_NEXT        = 3'd4;
   localparam logic [2:0] KIND_PREV        = 3'd5;
   localparam logic [2:0] KIND_JUMP        = 3'd6;
   localparam logic [2:0] KIND_OPEN_FAILED = 3'd7;

   localparam logic CSR_SHUFFLE = 1'b0;
   localparam logic CSR_REPEAT  = 1'b1;

   localparam logic [1:0] REPEAT_ALL = 2'd1;
   localparam logic [1:0] REPEAT_ONE = 2'd2;

   typedef enum logic [1:0] {
      PEND_NONE, PEND_DIRECT, PEND_FWD, PEND_BACK
   } pend_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_JUMP_RD, ST_JUMP_CHK, ST_SEARCH,
      ST_SCAN, ST_MUL, ST_ADD, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_FWD1, PH_FWD2, PH_BACK1, PH_BACK2, PH_COUNT, PH_NTH, PH_AVOID
   } phase_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        entry_is_folder;
      logic [7:0]  target_index;
      logic [15:0] elapsed_seconds;
      logic [31:0] timer_sample;
   } req_type;

   typedef struct packed {
      logic       action;
      logic [7:0] track_index;
      logic [8:0] queue_count;
   } rsp_type;

endpackage

### rtl/playlist_track_selector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Playlist track selector
// Picks the queue position to open next from a queue of playable and folder
// entries, with shuffle, repeat-all and repeat-one modes.
// ---------------------------------------------------------------------------
// The block takes one event word at a time and answers each with exactly one
// response word. A plain forward or backward search sweeps the one-bit folder
// memory one entry per cycle, with two passes when it wraps. A shuffled pick
// counts the playable entries in one sweep, steps the generator through a
// registered multiply, runs a 24-step remainder unit and sweeps again to find
// the chosen entry, with a third sweep when the pick must move off the current
// track. The single read port of the flag memory sets the pace of all sweeps.
// A finished response sits in an output register, so a new event word is
// accepted while the previous response waits to be taken.
// Configuration writes are accepted in every cycle.
// ---------------------------------------------------------------------------

`include "playlist_track_selector_macros.svh"

module playlist_track_selector import pts_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_word,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_word,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [1:0] csr_word
);

   // Position width, length width (holds the depth itself) and a compare width
   // wide enough for the 8-bit target field as well.
   localparam int IW  = $clog2(QUEUE_DEPTH);
   localparam int QLW = $clog2(QUEUE_DEPTH + 1);
   localparam int XW  = (QLW > 9) ? QLW : 9;
   localparam int AW  = QLW + 1;
   localparam int CW  = $clog2(RND_BITS + 1);

   state_type             state_ff, state_in;
   req_type               req_ff;
   logic                  shuffle_ff;
   logic [1:0]            repeat_ff;
   logic [QLW-1:0]        qlen_ff, qlen_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [31:0]           rs_ff, rs_in;
   logic [31:0]           prod_ff;
   pend_type              pend_ff, pend_in;
   pend_type              dir_ff, dir_in;
   logic [AW-1:0]         att_ff, att_in;
   logic [XW-1:0]         jt_ff, jt_in;
   logic                  res_act_ff, res_act_in;
   logic [IW-1:0]         res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   // Sweep engine: address counter, remaining entries, delayed check stage.
   phase_type             ph_ff, ph_in;
   logic [IW-1:0]         pos_ff, pos_in;
   logic [IW-1:0]         posd_ff;
   logic [IW-1:0]         pick_ff, pick_in;
   logic [QLW-1:0]        srem_ff, srem_in;
   logic [QLW-1:0]        n_ff, n_in;
   logic [QLW-1:0]        seen_ff, seen_in;
   logic [QLW-1:0]        tgt_ff, tgt_in;
   logic                  vd_ff, vd_in;

   // Remainder unit for the random pick.
   logic [RND_BITS-1:0]   dvd_ff, dvd_in;
   logic [QLW:0]          drem_ff, drem_in;
   logic [CW-1:0]         dcnt_ff, dcnt_in;
   logic [QLW:0]          drem_shift;

   // Folder flag memory, one bit per queue entry.
   logic                  flag_mem [QUEUE_DEPTH];
   logic                  rd_ff;
   logic                  rd_en;
   logic [IW-1:0]         rd_addr;
   logic                  mem_we;

   logic                  req_fire;
   logic                  rsp_load;
   logic [XW-1:0]         qlen_x, cur_x, jt_x, tgt_x;
   logic                  q_empty, cur_in_q, restart, replay, jt_in_q;
   logic [QLW-1:0]        cur1_q, j0_q, p1_q, up_q;
   logic [QLW-1:0]        fwd1_len;
   logic [IW-1:0]         fwd1_pos, back1_pos, last_pos, avoid_pos, pos_step;
   logic                  scan_up;
   logic                  playable_d, scan_hit, scan_end, is_repick;
   logic                  sc_next, sc_mul, sc_commit;
   logic [IW-1:0]         commit_idx;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Shared decode of the current event and queue state.
   always_comb begin
      qlen_x   = XW'(qlen_ff);
      cur_x    = XW'(cur_ff);
      jt_x     = jt_ff;
      tgt_x    = XW'(req_ff.target_index);
      q_empty  = (qlen_ff == '0);
      cur_in_q = (cur_x < qlen_x);
      jt_in_q  = (jt_x < qlen_x);
      restart  = !shuffle_ff && (req_ff.elapsed_seconds > RESTART_SECONDS);
      replay   = (repeat_ff == REPEAT_ONE) && cur_in_q;
      cur1_q   = QLW'(cur_ff) + QLW'(1);
      fwd1_len = (cur1_q < qlen_ff) ? (qlen_ff - cur1_q) : '0;
      fwd1_pos = IW'(cur1_q);
      j0_q     = cur_in_q ? QLW'(cur_ff) : qlen_ff;
      back1_pos = IW'(j0_q - QLW'(1));
      last_pos = IW'(qlen_ff - QLW'(1));
      p1_q     = QLW'(posd_ff) + QLW'(1);
      avoid_pos = (p1_q == qlen_ff) ? '0 : IW'(p1_q);
      scan_up  = (ph_ff != PH_BACK1) && (ph_ff != PH_BACK2);
      up_q     = QLW'(pos_ff) + QLW'(1);
      pos_step = scan_up ? ((up_q == qlen_ff) ? '0 : IW'(up_q)) : (pos_ff - IW'(1));
   end

   // Decisions at the end of a sweep. A hit in the nth-entry pass that lands on
   // the current track moves on to the next playable entry when there is one.
   always_comb begin
      playable_d = vd_ff && !rd_ff;
      scan_hit   = playable_d &&
                   ((ph_ff == PH_NTH) ? (seen_ff == tgt_ff) : (ph_ff != PH_COUNT));
      scan_end   = scan_hit || ((srem_ff == '0) && !vd_ff);
      is_repick  = (ph_ff == PH_NTH) && (n_ff > QLW'(1)) && (posd_ff == cur_ff);
      sc_next    = scan_hit ? is_repick
                            : (((ph_ff == PH_FWD1) && (repeat_ff == REPEAT_ALL)) ||
                               (ph_ff == PH_BACK1));
      sc_mul     = !scan_hit && (ph_ff == PH_COUNT) && (n_ff != '0);
      sc_commit  = scan_hit ? !is_repick : (ph_ff == PH_AVOID);
      commit_idx = scan_hit ? posd_ff : pick_ff;
      drem_shift = {drem_ff[QLW-1:0], dvd_ff[RND_BITS-1]};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (req_ff.kind)
               KIND_JUMP: state_in = ST_JUMP_RD;
               KIND_PREV: state_in = q_empty ? ST_DONE : (restart ? ST_JUMP_RD : ST_SEARCH);
               KIND_NEXT: state_in = q_empty ? ST_DONE : ST_SEARCH;
               KIND_END:  state_in = replay ? ST_DONE : ST_SEARCH;
               KIND_OPEN_FAILED: begin
                  unique case (pend_ff)
                     PEND_DIRECT: state_in = replay ? ST_DONE : ST_SEARCH;
                     PEND_FWD, PEND_BACK: state_in = ST_SEARCH;
                     default: state_in = ST_DONE;
                  endcase
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_JUMP_RD:  state_in = jt_in_q ? ST_JUMP_CHK : ST_DONE;
         ST_JUMP_CHK: state_in = ST_DONE;
         ST_SEARCH:   state_in = (att_ff > AW'(qlen_ff)) ? ST_DONE : ST_SCAN;
         ST_SCAN: begin
            if (scan_end) state_in = sc_mul ? ST_MUL : (sc_next ? ST_SCAN : ST_DONE);
         end
         ST_MUL: state_in = ST_ADD;
         ST_ADD: state_in = ST_DIV;
         ST_DIV: begin
            if (dcnt_ff == '0) state_in = ST_SCAN;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and result values.
   always_comb begin
      qlen_in    = qlen_ff;
      cur_in     = cur_ff;
      rs_in      = rs_ff;
      pend_in    = pend_ff;
      dir_in     = dir_ff;
      att_in     = att_ff;
      jt_in      = jt_ff;
      res_act_in = res_act_ff;
      res_idx_in = res_idx_ff;
      ph_in      = ph_ff;
      pos_in     = pos_ff;
      pick_in    = pick_ff;
      srem_in    = srem_ff;
      n_in       = n_ff;
      seen_in    = seen_ff;
      tgt_in     = tgt_ff;
      dvd_in     = dvd_ff;
      drem_in    = drem_ff;
      dcnt_in    = dcnt_ff;
      mem_we     = 1'b0;
      vd_in      = (state_ff == ST_SCAN) && (srem_ff != '0) && !scan_end;

      unique case (state_ff)
         ST_DISPATCH: begin
            unique case (req_ff.kind)
               KIND_CLEAR: begin
                  qlen_in    = '0;
                  pend_in    = PEND_NONE;
                  res_act_in = 1'b0;
               end
               KIND_ADD: begin
                  if (qlen_ff < QLW'(QUEUE_DEPTH)) begin
                     mem_we  = 1'b1;
                     qlen_in = qlen_ff + QLW'(1);
                  end
                  res_act_in = 1'b0;
               end
               KIND_START: begin
                  if (q_empty) begin
                     pend_in    = PEND_NONE;
                     res_act_in = 1'b0;
                  end else begin
                     cur_in     = (tgt_x < qlen_x) ? IW'(req_ff.target_index) : '0;
                     att_in     = '0;
                     pend_in    = PEND_DIRECT;
                     res_act_in = 1'b1;
                     res_idx_in = cur_in;
                  end
               end
               KIND_NEXT: begin
                  att_in     = '0;
                  dir_in     = PEND_FWD;
                  res_act_in = 1'b0;
               end
               KIND_PREV: begin
                  // A restart on a folder must leave the retry count alone.
                  if (!restart) att_in = '0;
                  dir_in     = PEND_BACK;
                  jt_in      = cur_x;
                  res_act_in = 1'b0;
               end
               KIND_JUMP: begin
                  jt_in = tgt_x;
               end
               KIND_END, KIND_OPEN_FAILED: begin
                  res_act_in = 1'b0;
                  if (req_ff.kind == KIND_END || pend_ff == PEND_DIRECT) begin
                     // Fresh advance: replay the current track in repeat-one mode.
                     att_in = '0;
                     dir_in = PEND_FWD;
                     if (replay) begin
                        pend_in    = PEND_FWD;
                        res_act_in = 1'b1;
                        res_idx_in = cur_ff;
                     end
                  end else begin
                     dir_in = pend_ff;
                  end
               end
               default: res_act_in = 1'b0;
            endcase
         end
         ST_JUMP_RD: begin
            res_act_in = 1'b0;
         end
         ST_JUMP_CHK: begin
            if (!rd_ff) begin
               cur_in     = IW'(jt_ff);
               att_in     = '0;
               pend_in    = PEND_DIRECT;
               res_act_in = 1'b1;
               res_idx_in = IW'(jt_ff);
            end
         end
         ST_SEARCH: begin
            seen_in = '0;
            n_in    = '0;
            if (att_ff > AW'(qlen_ff)) begin
               pend_in    = PEND_NONE;
               res_act_in = 1'b0;
            end else if (shuffle_ff) begin
               ph_in   = PH_COUNT;
               pos_in  = '0;
               srem_in = qlen_ff;
            end else if (dir_ff == PEND_FWD) begin
               ph_in   = PH_FWD1;
               pos_in  = fwd1_pos;
               srem_in = fwd1_len;
            end else begin
               ph_in   = PH_BACK1;
               pos_in  = back1_pos;
               srem_in = j0_q;
            end
         end
         ST_SCAN: begin
            if (srem_ff != '0) begin
               pos_in  = pos_step;
               srem_in = srem_ff - QLW'(1);
            end
            if (playable_d && ph_ff == PH_NTH)   seen_in = seen_ff + QLW'(1);
            if (playable_d && ph_ff == PH_COUNT) n_in    = n_ff + QLW'(1);
            if (scan_end) begin
               if (sc_commit) begin
                  att_in     = att_ff + AW'(1);
                  cur_in     = commit_idx;
                  pend_in    = dir_ff;
                  res_act_in = 1'b1;
                  res_idx_in = commit_idx;
               end else if (sc_next) begin
                  if (scan_hit) begin
                     ph_in   = PH_AVOID;
                     pick_in = posd_ff;
                     pos_in  = avoid_pos;
                     srem_in = qlen_ff - QLW'(1);
                  end else if (ph_ff == PH_FWD1) begin
                     ph_in   = PH_FWD2;
                     pos_in  = '0;
                     srem_in = qlen_ff;
                  end else begin
                     ph_in   = PH_BACK2;
                     pos_in  = last_pos;
                     srem_in = qlen_ff;
                  end
               end else if (!sc_mul) begin
                  pend_in    = PEND_NONE;
                  res_act_in = 1'b0;
               end
            end
         end
         ST_ADD: begin
            rs_in   = prod_ff + LCG_ADD + req_ff.timer_sample;
            dvd_in  = rs_in[31:8];
            drem_in = '0;
            dcnt_in = CW'(RND_BITS);
         end
         ST_DIV: begin
            if (dcnt_ff != '0) begin
               drem_in = (drem_shift >= {1'b0, n_ff}) ? (drem_shift - {1'b0, n_ff})
                                                      : drem_shift;
               dvd_in  = {dvd_ff[RND_BITS-2:0], 1'b0};
               dcnt_in = dcnt_ff - CW'(1);
            end else begin
               tgt_in  = QLW'(drem_ff);
               ph_in   = PH_NTH;
               pos_in  = '0;
               srem_in = qlen_ff;
               seen_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Flag memory: written by add, read by the sweeps and by jumps and restarts.
   assign rd_en   = ((state_ff == ST_SCAN) && (srem_ff != '0)) ||
                    ((state_ff == ST_JUMP_RD) && jt_in_q);
   assign rd_addr = (state_ff == ST_JUMP_RD) ? IW'(jt_ff) : pos_ff;

   always_ff @(posedge clock) begin
      if (mem_we) flag_mem[IW'(qlen_ff)] <= req_ff.entry_is_folder;
      if (rd_en)  rd_ff <= flag_mem[rd_addr];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_word;
      if (state_ff == ST_MUL) prod_ff <= 32'(rs_ff * LCG_MUL);
      if (rsp_load) begin
         rsp_ff.action      <= res_act_ff;
         rsp_ff.track_index <= res_act_ff ? 8'(res_idx_ff) : 8'd0;
         rsp_ff.queue_count <= 9'(qlen_ff);
      end
      dir_ff     <= dir_in;
      jt_ff      <= jt_in;
      res_act_ff <= res_act_in;
      res_idx_ff <= res_idx_in;
      ph_ff      <= ph_in;
      pos_ff     <= pos_in;
      posd_ff    <= pos_ff;
      pick_ff    <= pick_in;
      srem_ff    <= srem_in;
      n_ff       <= n_in;
      seen_ff    <= seen_in;
      tgt_ff     <= tgt_in;
      dvd_ff     <= dvd_in;
      drem_ff    <= drem_in;
      dcnt_ff    <= dcnt_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         qlen_ff      <= '0;
         cur_ff       <= '0;
         rs_ff        <= LCG_SEED;
         pend_ff      <= PEND_NONE;
         att_ff       <= '0;
         shuffle_ff   <= 1'b0;
         repeat_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
         vd_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         qlen_ff  <= qlen_in;
         cur_ff   <= cur_in;
         rs_ff    <= rs_in;
         pend_ff  <= pend_in;
         att_ff   <= att_in;
         vd_ff    <= vd_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SHUFFLE: shuffle_ff <= csr_word[0];
               CSR_REPEAT:  repeat_ff  <= csr_word;
               default:     shuffle_ff <= shuffle_ff;
            endcase
         end
      end
   end

   // An accepted event word is decoded in the following cycle.
   `PTS_ASSERT_NEXT(a_accept_dispatch, req_fire, state_ff == ST_DISPATCH)
   // A response handed over from the done state is registered as valid and frees the block.
   `PTS_ASSERT_NEXT(a_done_to_rsp, rsp_load, rsp_valid_ff && state_ff == ST_IDLE)
   // The queue never holds more entries than the memory has.
   `PTS_ASSERT_NOW(a_qlen_bound, 1'b1, qlen_ff <= QLW'(QUEUE_DEPTH))
   // Sweeps only read entries that lie inside the queue.
   `PTS_ASSERT_NOW(a_scan_in_range, state_ff == ST_SCAN && srem_ff != '0,
                   QLW'(pos_ff) < qlen_ff)

endmodule
